[design/ssr_pkg.sv]
`default_nettype none
package ssr_pkg;

	localparam int FRAC_BITS = 8;
	localparam int SEP = 10 << FRAC_BITS;
	localparam int DSQ_ONE = 1 << (2 * FRAC_BITS);
	localparam int DSQ_MIN = DSQ_ONE / 10000;
	localparam int DSQ_MAX = 100 * DSQ_ONE;
	localparam int PUSH_GAIN = 200;

	localparam logic [15:0] TIME_STEP_RST = 16'd1092;
	localparam logic [11:0] WORLD_W_RST = 12'd800;
	localparam logic [11:0] WORLD_H_RST = 12'd600;

	localparam logic [1:0] REG_TIME_STEP = 2'd0;
	localparam logic [1:0] REG_WORLD_W = 2'd1;
	localparam logic [1:0] REG_WORLD_H = 2'd2;

	// request to the shared root/divide unit
	typedef struct packed {
		logic start;
		logic is_div;
	} unit_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
		else if (v < -34'sh0_8000_0000) r = 32'sh8000_0000;
		else r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
		logic signed [31:0] r;
		if (v == 32'sh8000_0000) r = 32'sh7FFF_FFFF;
		else r = -v;
		return r;
	endfunction

endpackage
`default_nettype wire

[design/ssr_root_div.sv]
`default_nettype none
module ssr_root_div
	import ssr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire unit_req_t   req,
	input  wire logic [47:0] opa,
	input  wire logic [11:0] divisor,
	output unit_stat_t       stat,
	output logic      [47:0] result
);

	logic        busy_q, done_q, div_q;
	logic [5:0]  cnt_q;
	logic [47:0] num_q, res_q;
	logic [15:0] rem_q;
	logic [15:0] shifted, trial;
	logic [16:0] diff;
	logic        ge;

	// one restoring step: two radicand bits for the root, one dividend bit for the quotient
	always_comb begin
		if (div_q) begin
			shifted = {rem_q[14:0], num_q[47]};
			trial   = {4'b0, divisor};
		end else begin
			shifted = {rem_q[13:0], num_q[47:46]};
			trial   = {res_q[13:0], 2'b01};
		end
		diff = {1'b0, shifted} - {1'b0, trial};
		ge   = ~diff[16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && cnt_q == 6'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.is_div;
			num_q <= req.is_div ? opa : {opa[23:0], 24'b0};
			rem_q <= '0;
			res_q <= '0;
			cnt_q <= req.is_div ? 6'd47 : 6'd11;
		end else if (busy_q) begin
			num_q <= div_q ? {num_q[46:0], 1'b0} : {num_q[45:0], 2'b0};
			rem_q <= ge ? diff[15:0] : shifted;
			res_q <= {res_q[46:0], ge};
			cnt_q <= cnt_q - 6'd1;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result = res_q;

endmodule
`default_nettype wire

[design/soft_sphere_repulsion_integrator.sv]
`default_nettype none
// Sequence: an item with no neighbor work goes through S_DIFF and S_INTEG; a pushing neighbor
// adds a 12-step root and two 48-step divides on the shared unit; the last item adds the move
// and clamp of x, then the move and clamp of y, and then the result hand-off.
// Throughput: one item at a time; input stalls while an item's work runs or a result waits to go out.
// Reset (arst_n, async): clear held state, drop any pending result, load register defaults.
module soft_sphere_repulsion_integrator
	import ssr_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] own_x,
	input  wire logic signed [31:0] own_y,
	input  wire logic signed [31:0] own_vx,
	input  wire logic signed [31:0] own_vy,
	input  wire logic               is_collider,
	input  wire logic signed [31:0] neighbor_x,
	input  wire logic signed [31:0] neighbor_y,
	input  wire logic               neighbor_valid,
	input  wire logic               is_first,
	input  wire logic               is_last,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      new_x,
	output logic signed [31:0]      new_y,
	output logic signed [31:0]      new_vx,
	output logic signed [31:0]      new_vy,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_wr_data
);

	typedef enum logic [15:0] {
		S_IDLE  = 16'h0001,
		S_DIFF  = 16'h0002,
		S_SQX   = 16'h0004,
		S_SQY   = 16'h0008,
		S_SUM   = 16'h0010,
		S_ROOT  = 16'h0020,
		S_M1    = 16'h0040,
		S_M2    = 16'h0080,
		S_M3    = 16'h0100,
		S_DIV   = 16'h0200,
		S_ACC   = 16'h0400,
		S_INTEG = 16'h0800,
		S_MVX   = 16'h1000,
		S_CLX   = 16'h2000,
		S_MVY   = 16'h4000,
		S_CLY   = 16'h8000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [15:0] time_step_q;
	logic [11:0] world_w_q, world_h_q;

	// held particle state
	logic signed [31:0] held_x_q, held_y_q, vx_q, vy_q;
	logic               collider_q;

	// per-item request fields
	logic signed [31:0] nb_x_q, nb_y_q;
	logic               nb_valid_q, last_q;

	// working registers
	logic signed [32:0] dx_q, dy_q;
	logic [24:0]        dsq_q;
	logic [11:0]        dist_q, overlap_q;
	logic               axis_q;
	logic [47:0]        prod_q;
	logic               pend_q;
	logic signed [31:0] out_x_q, out_y_q, out_vx_q, out_vy_q;
	logic               out_valid_q;

	// shared multiplier operands
	logic [31:0] mul_a;
	logic [15:0] mul_b;

	unit_req_t   u_req;
	unit_stat_t  u_stat;
	logic [47:0] u_res;

	logic signed [32:0] d_sel, dx_abs, dy_abs, d_abs;
	logic signed [31:0] v_sel;
	logic [31:0]        v_abs, move_mag, push_mag;
	logic signed [33:0] step, pos, hi, v_sum;
	logic signed [31:0] pos_new, v_new;
	logic [11:0]        wall;
	logic               in_range, near, in_acc, out_free;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE) || pend_q;
	assign out_free = !out_valid_q || !out_stall;

	assign dx_abs = dx_q[32] ? -dx_q : dx_q;
	assign dy_abs = dy_q[32] ? -dy_q : dy_q;
	assign d_sel  = axis_q ? dy_q : dx_q;
	assign d_abs  = axis_q ? dy_abs : dx_abs;
	assign v_sel  = axis_q ? vy_q : vx_q;
	assign v_abs  = v_sel[31] ? 32'(-v_sel) : 32'(v_sel);

	assign in_range = (dx_q > -33'(SEP)) && (dx_q < 33'(SEP)) &&
	                  (dy_q > -33'(SEP)) && (dy_q < 33'(SEP));

	// sum of squares is complete in S_SUM as dsq_q + prod_q
	logic [24:0] dsq_full;
	assign dsq_full = dsq_q + prod_q[24:0];
	assign near     = (dsq_full > 25'(DSQ_MIN)) && (dsq_full < 25'(DSQ_MAX));

	// push: quotient >> 16 fits below 2^31
	assign push_mag = u_res[47:16];
	assign v_sum = d_sel[32] ? (34'(v_sel) - $signed({2'b0, push_mag}))
	                         : (34'(v_sel) + $signed({2'b0, push_mag}));

	// move: magnitude of v*dt truncated, then signed
	assign move_mag = prod_q[47:16];
	assign step = v_sel[31] ? -$signed({2'b0, move_mag}) : $signed({2'b0, move_mag});
	assign pos  = (axis_q ? 34'(held_y_q) : 34'(held_x_q)) + step;
	assign wall = axis_q ? world_h_q : world_w_q;
	assign hi   = $signed({14'b0, wall, 8'b0});

	always_comb begin
		pos_new = pos[31:0];
		v_new   = v_sel;
		if (pos < 34'sd0) begin
			pos_new = '0;
			v_new   = neg_sat(v_sel);
		end else if (pos > hi) begin
			pos_new = hi[31:0];
			v_new   = neg_sat(v_sel);
		end
	end

	// operand select for the one shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQX: begin
				mul_a = {20'b0, dx_abs[11:0]};
				mul_b = {4'b0, dx_abs[11:0]};
			end
			S_SQY: begin
				mul_a = {20'b0, dy_abs[11:0]};
				mul_b = {4'b0, dy_abs[11:0]};
			end
			S_M1: begin
				mul_a = {20'b0, d_abs[11:0]};
				mul_b = {4'b0, overlap_q};
			end
			S_M2: begin
				mul_a = prod_q[31:0];
				mul_b = 16'(PUSH_GAIN);
			end
			S_M3, S_MVX, S_MVY: begin
				mul_a = (state_q == S_M3) ? prod_q[31:0] : v_abs;
				mul_b = time_step_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		u_req.start  = 1'b0;
		u_req.is_div = 1'b0;
		if (state_q == S_SUM && in_range && near) u_req.start = 1'b1;
		if (state_q == S_M3 || (state_q == S_DIV && 1'b0)) u_req.start = 1'b0;
		if (state_q == S_DIV && !u_stat.busy && !u_stat.done && !pend_q) begin
			u_req.start  = 1'b1;
			u_req.is_div = 1'b1;
		end
	end

	ssr_root_div u_unit (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (u_req),
		.opa     (state_q == S_DIV ? prod_q : {23'b0, dsq_full}),
		.divisor (dist_q),
		.stat    (u_stat),
		.result  (u_res)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
			world_w_q   <= WORLD_W_RST;
			world_h_q   <= WORLD_H_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_wr_data;
				REG_WORLD_W:   world_w_q   <= cfg_wr_data[11:0];
				REG_WORLD_H:   world_h_q   <= cfg_wr_data[11:0];
				default:       ;
			endcase
		end
	end

	// sequencer and held state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			held_x_q    <= '0;
			held_y_q    <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			collider_q  <= 1'b0;
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			axis_q      <= 1'b0;
		end else begin
			// hand a finished result to the output register once it is free
			if (pend_q && out_free) begin
				out_x_q     <= held_x_q;
				out_y_q     <= held_y_q;
				out_vx_q    <= vx_q;
				out_vy_q    <= vy_q;
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (is_first) begin
							held_x_q   <= own_x;
							held_y_q   <= own_y;
							vx_q       <= own_vx;
							vy_q       <= own_vy;
							collider_q <= is_collider;
						end
						nb_x_q     <= neighbor_x;
						nb_y_q     <= neighbor_y;
						nb_valid_q <= neighbor_valid;
						last_q     <= is_last;
						state_q    <= S_DIFF;
					end
				end
				S_DIFF: begin
					dx_q    <= 33'(held_x_q) - 33'(nb_x_q);
					dy_q    <= 33'(held_y_q) - 33'(nb_y_q);
					state_q <= (collider_q && nb_valid_q) ? S_SQX : S_INTEG;
				end
				S_SQX: state_q <= in_range ? S_SQY : S_INTEG;
				S_SQY: begin
					dsq_q   <= prod_q[24:0];
					state_q <= S_SUM;
				end
				S_SUM: state_q <= near ? S_ROOT : S_INTEG;
				S_ROOT: begin
					if (u_stat.done) begin
						dist_q    <= u_res[11:0];
						overlap_q <= 12'(SEP) - u_res[11:0];
						axis_q    <= 1'b0;
						state_q   <= S_M1;
					end
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_DIV;
				S_DIV: if (u_stat.done) state_q <= S_ACC;
				S_ACC: begin
					if (axis_q) vy_q <= sat32(v_sum);
					else vx_q <= sat32(v_sum);
					axis_q  <= ~axis_q;
					state_q <= axis_q ? S_INTEG : S_M1;
				end
				S_INTEG: begin
					axis_q  <= 1'b0;
					state_q <= last_q ? S_MVX : S_IDLE;
				end
				S_MVX: state_q <= S_CLX;
				S_CLX: begin
					held_x_q <= pos_new;
					vx_q     <= v_new;
					axis_q   <= 1'b1;
					state_q  <= S_MVY;
				end
				S_MVY: state_q <= S_CLY;
				S_CLY: begin
					held_y_q <= pos_new;
					vy_q     <= v_new;
					axis_q   <= 1'b0;
					pend_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_q <= 48'(mul_a) * 48'(mul_b);
	end

	assign out_valid = out_valid_q;
	assign new_x     = out_x_q;
	assign new_y     = out_y_q;
	assign new_vx    = out_vx_q;
	assign new_vy    = out_vy_q;

endmodule
`default_nettype wire

[tb/sv/tb_top.sv]
`default_nettype none
module tb_top;
	import ssr_pkg::*;

	// one request on the input channel
	typedef struct {
		logic signed [31:0] px, py, pvx, pvy;
		logic               collider;
		logic signed [31:0] nx, ny;
		logic               nvalid, first, last;
	} particle_req_t;

	// one step result
	typedef struct {
		logic signed [31:0] x, y, vx, vy;
	} step_result_t;

	// Tracks the particle state and the pending step results.
	class step_scoreboard;
		logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
		logic               collides;
		logic [15:0]        dt;
		logic [11:0]        wall_w, wall_h;
		step_result_t       pending[$];
		int                 errors;

		function void clear();
			pos_x = 0; pos_y = 0; vel_x = 0; vel_y = 0; collides = 0;
			dt = TIME_STEP_RST; wall_w = WORLD_W_RST; wall_h = WORLD_H_RST;
			errors = 0;
		endfunction

		function logic signed [31:0] clip32(longint v);
			if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
			if (v < -64'sd2147483648) return 32'sh8000_0000;
			return v[31:0];
		endfunction

		function longint unsigned root_floor(longint unsigned n);
			longint unsigned r, b;
			r = 0;
			b = 64'd1 << 62;
			while (b > n) b >>= 2;
			while (b != 0) begin
				if (n >= r + b) begin
					n -= r + b;
					r = (r >> 1) + b;
				end else begin
					r >>= 1;
				end
				b >>= 2;
			end
			return r;
		endfunction

		function longint push(longint d, longint unsigned ovl, longint unsigned span);
			longint unsigned m;
			m = (d < 0) ? -d : d;
			m = m * ovl * 200 * dt;
			m = (m / span) >> 16;
			return (d < 0) ? -longint'(m) : longint'(m);
		endfunction

		function longint travel(logic signed [31:0] v);
			longint p;
			longint unsigned m;
			p = longint'(v) * longint'({1'b0, dt});
			m = ((p < 0) ? -p : p) >> 16;
			return (p < 0) ? -longint'(m) : longint'(m);
		endfunction

		// clamp one axis, flip its velocity on a wall hit
		function void bound(longint p, logic [11:0] wall,
				ref logic signed [31:0] q, ref logic signed [31:0] v);
			longint hi;
			hi = longint'(wall) << FRAC_BITS;
			if (p < 0) begin
				p = 0;
				v = clip32(-longint'(v));
			end else if (p > hi) begin
				p = hi;
				v = clip32(-longint'(v));
			end
			q = clip32(p);
		endfunction

		function void note_request(particle_req_t r);
			longint dx, dy;
			longint unsigned dsq, span;
			step_result_t e;
			if (r.first) begin
				pos_x = r.px; pos_y = r.py; vel_x = r.pvx; vel_y = r.pvy;
				collides = r.collider;
			end
			if (collides && r.nvalid) begin
				dx = longint'(pos_x) - longint'(r.nx);
				dy = longint'(pos_y) - longint'(r.ny);
				if (dx > -SEP && dx < SEP && dy > -SEP && dy < SEP) begin
					dsq = dx * dx + dy * dy;
					if (dsq * 10000 > DSQ_ONE && dsq < DSQ_MAX) begin
						span = root_floor(dsq);
						if (span != 0) begin
							vel_x = clip32(longint'(vel_x) + push(dx, SEP - span, span));
							vel_y = clip32(longint'(vel_y) + push(dy, SEP - span, span));
						end
					end
				end
			end
			if (r.last) begin
				bound(longint'(pos_x) + travel(vel_x), wall_w, pos_x, vel_x);
				bound(longint'(pos_y) + travel(vel_y), wall_h, pos_y, vel_y);
				e.x = pos_x; e.y = pos_y; e.vx = vel_x; e.vy = vel_y;
				pending.push_back(e);
			end
		endfunction

		task report(string what, logic signed [31:0] got, logic signed [31:0] want);
			$display("MISMATCH %s: got %0d want %0d", what, got, want);
			errors++;
		endtask

		task check_result(step_result_t g);
			step_result_t w;
			if (pending.size() == 0) begin
				report("unexpected result new_x", g.x, 0);
				return;
			end
			w = pending.pop_front();
			if (g.x !== w.x) report("new_x", g.x, w.x);
			if (g.y !== w.y) report("new_y", g.y, w.y);
			if (g.vx !== w.vx) report("new_vx", g.vx, w.vx);
			if (g.vy !== w.vy) report("new_vy", g.vy, w.vy);
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_stall, out_valid, out_stall;
	logic signed [31:0] own_x, own_y, own_vx, own_vy, neighbor_x, neighbor_y;
	logic is_collider, neighbor_valid, is_first, is_last;
	logic signed [31:0] new_x, new_y, new_vx, new_vy;
	logic cfg_wr_en;
	logic [1:0] cfg_index;
	logic [15:0] cfg_wr_data;

	step_scoreboard sb;
	int idle_cycles;
	int accepted;
	bit hold_req;

	soft_sphere_repulsion_integrator DUT (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// pick a gap: mostly none, sometimes short, rarely long
	function int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// offer one request and hold it until the block takes it
	task send(particle_req_t r);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		own_x <= r.px; own_y <= r.py; own_vx <= r.pvx; own_vy <= r.pvy;
		is_collider <= r.collider; neighbor_x <= r.nx; neighbor_y <= r.ny;
		neighbor_valid <= r.nvalid; is_first <= r.first; is_last <= r.last;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		sb.note_request(r);
		accepted++;
	endtask

	function logic signed [31:0] rnd32();
		return $urandom();
	endfunction

	// neighbor placed around the held position; mostly inside the push radius
	function void aim(ref particle_req_t r, input logic signed [31:0] cx,
			input logic signed [31:0] cy);
		int k;
		k = $urandom_range(0, 19);
		r.nvalid = ($urandom_range(0, 9) != 0);
		if (k == 0) begin
			r.nx = rnd32(); r.ny = rnd32();
		end else if (k == 1) begin
			r.nx = cx; r.ny = cy;
		end else if (k == 2) begin
			r.nx = cx + $urandom_range(0, 6) - 3; r.ny = cy;
		end else begin
			r.nx = cx + int'($urandom_range(0, 6000)) - 3000;
			r.ny = cy + int'($urandom_range(0, 6000)) - 3000;
		end
	endfunction

	// one particle run: load, a few neighbors, integrate
	task particle_run(int n_nb, bit wild);
		particle_req_t r;
		logic signed [31:0] cx, cy;
		int i;
		r.first = ($urandom_range(0, 9) != 0);
		r.collider = ($urandom_range(0, 7) != 0);
		if (wild) begin
			r.px = rnd32(); r.py = rnd32(); r.pvx = rnd32(); r.pvy = rnd32();
		end else begin
			r.px = $urandom_range(0, (sb.wall_w << 8) + 512) - 256;
			r.py = $urandom_range(0, (sb.wall_h << 8) + 512) - 256;
			r.pvx = int'($urandom_range(0, 400000)) - 200000;
			r.pvy = int'($urandom_range(0, 400000)) - 200000;
		end
		cx = r.first ? r.px : sb.pos_x;
		cy = r.first ? r.py : sb.pos_y;
		for (i = 0; i <= n_nb; i++) begin
			aim(r, cx, cy);
			r.last = (i == n_nb);
			send(r);
			r.first = 0;
			// later items carry junk in the load fields, which must be ignored
			r.px = rnd32(); r.py = rnd32(); r.pvx = rnd32(); r.pvy = rnd32();
			r.collider = 1'($urandom_range(0, 1));
		end
	endtask

	// drop the request, drain outstanding results, then let any neighbor work finish
	task settle();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_wr_en <= 1; cfg_index <= idx; cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 0;
		case (idx)
			REG_TIME_STEP: sb.dt = val;
			REG_WORLD_W:   sb.wall_w = val[11:0];
			default:       sb.wall_h = val[11:0];
		endcase
	endtask

	task set_world(logic [15:0] ts, logic [11:0] w, logic [11:0] h);
		settle();
		write_reg(REG_TIME_STEP, ts);
		write_reg(REG_WORLD_W, {4'd0, w});
		write_reg(REG_WORLD_H, {4'd0, h});
	endtask

	// hand-picked cases before the random runs
	task directed();
		particle_req_t r;
		r = '{default: 0};
		// last without first: integrates the zeroed reset state
		r.last = 1; send(r);
		// one-item run with a pushing neighbor
		r = '{px: 1000, py: 1000, pvx: 0, pvy: 0, collider: 1, nx: 900, ny: 1100,
			nvalid: 1, first: 1, last: 1};
		send(r);
		// continue from the written-back state
		r.first = 0; r.nx = sb.pos_x + 5; r.ny = sb.pos_y; send(r);
		// coincident neighbor, near-coincident ones, one just inside and one just outside the radius
		r = '{px: 5000, py: 5000, pvx: 100, pvy: -100, collider: 1, nx: 5000, ny: 5000,
			nvalid: 1, first: 1, last: 0};
		send(r);
		r.first = 0; r.nx = 5002; send(r);
		r.nx = 5003; send(r);
		r.nx = 5000 - 2559; send(r);
		r.nx = 5000 + 2560; r.last = 1; send(r);
		// non-collider ignores a close neighbor
		r = '{px: 2000, py: 2000, pvx: 5000, pvy: 5000, collider: 0, nx: 2010, ny: 2010,
			nvalid: 1, first: 1, last: 1};
		send(r);
		// wall hits on all four sides, extreme velocities
		r = '{px: 0, py: 0, pvx: 32'sh8000_0000, pvy: 32'sh8000_0000, collider: 0,
			nx: 0, ny: 0, nvalid: 0, first: 1, last: 1};
		send(r);
		r.px = 32'sh7FFF_FFFF; r.py = 32'sh7FFF_FFFF;
		r.pvx = 32'sh7FFF_FFFF; r.pvy = 32'sh7FFF_FFFF; send(r);
		r.px = 32'sh8000_0000; r.py = 32'sh8000_0000; r.pvx = -1; r.pvy = 1; send(r);
		// velocity saturation on a strong push
		r = '{px: 100000, py: 100000, pvx: 32'sh7FFF_FF00, pvy: 32'sh8000_0100,
			collider: 1, nx: 99990, ny: 100010, nvalid: 1, first: 1, last: 1};
		send(r);
		// invalid neighbor flagged close
		r.nvalid = 0; r.nx = 100001; send(r);
	endtask

	int phase;
	initial begin
		sb = new();
		sb.clear();
		arst_n = 0;
		in_valid = 0; out_stall = 0; cfg_wr_en = 0; cfg_index = 0; cfg_wr_data = 0;
		own_x = 0; own_y = 0; own_vx = 0; own_vy = 0; is_collider = 0;
		neighbor_x = 0; neighbor_y = 0; neighbor_valid = 0; is_first = 0; is_last = 0;
		hold_req = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		directed();
		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				1: set_world(16'hFFFF, 12'hFFF, 12'hFFF);
				2: set_world(16'd0, 12'd0, 12'd0);
				3: set_world(16'd1, 12'd1, 12'd1);
				4: set_world(16'($urandom()), 12'($urandom()), 12'($urandom()));
				5: set_world(16'd30000, 12'd50, 12'd40);
				default: ;
			endcase
			while (accepted < 25 + (phase + 1) * 220) begin
				if (phase == 0 && accepted > 120 && !hold_req) hold_req = 1;
				if ($urandom_range(0, 9) == 0) particle_run($urandom_range(0, 3), 1);
				else particle_run($urandom_range(0, 5), 0);
			end
		end
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (sb.errors == 0) $display("soft_sphere_repulsion_integrator verification clean");
		else $display("soft_sphere_repulsion_integrator verification failed");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off while requests keep coming
	initial begin
		int n;
		bit held;
		held = 0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				held = 1;
				out_stall <= 1;
				repeat (600) @(posedge clk);
			end
			n = gap_len();
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			repeat ($urandom_range(1, 40)) @(posedge clk);
		end
	end

	// check each accepted result against the oldest pending one
	always @(posedge clk) begin
		step_result_t g;
		if (arst_n && out_valid && !out_stall) begin
			g.x = new_x; g.y = new_y; g.vx = new_vx; g.vy = new_vy;
			sb.check_result(g);
		end
	end

	// watchdog: too long without any handshake on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("soft_sphere_repulsion_integrator verification failed");
			$finish;
		end
	end

endmodule
`default_nettype wire

[soft_sphere_repulsion_integrator.f]
design/ssr_pkg.sv
design/ssr_root_div.sv
design/soft_sphere_repulsion_integrator.sv
tb/sv/tb_top.sv
